@@ hw/rtl/sol_pkg.sv @@
package sol_pkg;

   // Field and register widths.
   localparam int IN_W   = 16;
   localparam int CLIP_W = 15;
   localparam int OQ_W   = 11;
   localparam int ES_W   = 13;
   localparam int SUM_W  = 32;
   localparam int SQ_W   = 2 * CLIP_W;
   localparam int DEN_W  = CLIP_W + OQ_W;
   localparam int DIV_W  = 45;
   localparam int CNT_W  = 6;
   localparam int DIV_STEPS = DIV_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = CLIP_W;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LIMIT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_QUANT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EVAL_SCALE   = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [CLIP_W-1:0] CLIP_LIMIT_RST   = 15'd255;
   localparam logic [OQ_W-1:0]   OUTPUT_QUANT_RST = 11'd64;
   localparam logic [ES_W-1:0]   EVAL_SCALE_RST   = 13'd400;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_DIV1_START,
      ST_DIV1_WAIT,
      ST_BIAS,
      ST_SCALE,
      ST_DIV2_START,
      ST_DIV2_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic div1_start;
      logic load_t;
      logic load_scale;
      logic div2_start;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic acc_last;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/screlu_output_layer_core.sv @@
// Output layer of a quantized neural evaluator. Each input word carries one
// hidden neuron and its output weight; the neuron is clamped to 0..clip_limit,
// squared, multiplied by the weight and added into a 32-bit running sum that
// wraps like a C int. A word with last_item set closes the evaluation: the sum
// is divided by clip_limit (truncating toward zero), bias_value is added, the
// value is multiplied by eval_scale and divided by clip_limit * output_quant,
// and the low 32 bits come out as score, after which the sum starts again at
// zero. Register values of zero for clip_limit or output_quant act as one.
// Neuron words that do not end an evaluation are taken one per clock through
// a four-stage multiply-accumulate pipeline. A word with last_item set holds
// off the input while the pipeline drains, through two passes of a shared
// bit-serial divider and through the bias add, the scale multiply and loading
// the result. The result sits in an output register, so the next evaluation
// can start while the previous score still waits to be taken. Configuration
// writes are taken in any cycle (csr_ready is always high) and must be made
// while the block is idle; a write to an index past the last register is
// ignored.
module screlu_output_layer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sol_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sol_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sol_pkg::IN_W-1:0]       req_neuron_value,
   input  logic signed [sol_pkg::IN_W-1:0]       req_weight,
   input  logic signed [sol_pkg::IN_W-1:0]       req_bias_value,
   input  logic                                  req_last_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [sol_pkg::SUM_W-1:0]      rsp_score
);

   // Configuration registers, as written.
   logic [sol_pkg::CLIP_W-1:0]  clip_limit_ff;
   logic [sol_pkg::OQ_W-1:0]    output_quant_ff;
   logic [sol_pkg::ES_W-1:0]    eval_scale_ff;

   // Values seen by the datapath: a zero clamp or quantizer behaves as one.
   logic [sol_pkg::CLIP_W-1:0]  clip_eff;
   logic [sol_pkg::OQ_W-1:0]    quant_eff;

   sol_pkg::cmd_type            cmd;
   sol_pkg::status_type         status;

   assign csr_ready = 1'b1;
   assign clip_eff  = (clip_limit_ff == '0) ? sol_pkg::CLIP_W'(1) : clip_limit_ff;
   assign quant_eff = (output_quant_ff == '0) ? sol_pkg::OQ_W'(1) : output_quant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_limit_ff   <= sol_pkg::CLIP_LIMIT_RST;
         output_quant_ff <= sol_pkg::OUTPUT_QUANT_RST;
         eval_scale_ff   <= sol_pkg::EVAL_SCALE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sol_pkg::CSR_CLIP_LIMIT:   clip_limit_ff <= csr_wdata;
            sol_pkg::CSR_OUTPUT_QUANT: output_quant_ff <= csr_wdata[sol_pkg::OQ_W-1:0];
            sol_pkg::CSR_EVAL_SCALE:   eval_scale_ff <= csr_wdata[sol_pkg::ES_W-1:0];
            default: begin
               // Unmapped index: the write has no effect.
               clip_limit_ff <= clip_limit_ff;
            end
         endcase
      end
   end

   // The controller sequences accumulation, the two divisions and the
   // result load; the datapath holds the arithmetic and the divider.
   sol_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .status        (status),
      .req_stall     (req_stall),
      .cmd           (cmd)
   );

   sol_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .clip_limit       (clip_eff),
      .output_quant     (quant_eff),
      .eval_scale       (eval_scale_ff),
      .req_neuron_value (req_neuron_value),
      .req_weight       (req_weight),
      .req_bias_value   (req_bias_value),
      .req_last_item    (req_last_item),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_score        (rsp_score)
   );

endmodule

@@ hw/rtl/sol_div.sv @@
module sol_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sol_pkg::DIV_W-1:0]   dividend,
   input  logic [sol_pkg::DEN_W-1:0]   divisor,
   output logic                        busy,
   output logic                        done,
   output logic [sol_pkg::DIV_W-1:0]   quotient
);

   // Restoring division, one quotient bit per cycle, MSB first.
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [sol_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [sol_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [sol_pkg::DIV_W-1:0]   quo_ff, quo_in;
   logic [sol_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [sol_pkg::DEN_W:0]     trial;
   logic                        fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[sol_pkg::DIV_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = sol_pkg::CNT_W'(sol_pkg::DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? sol_pkg::DEN_W'(trial - {1'b0, den_ff})
                       : trial[sol_pkg::DEN_W-1:0];
         quo_in = {quo_ff[sol_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hw/rtl/sol_datapath.sv @@
module sol_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  sol_pkg::cmd_type                   cmd,
   output sol_pkg::status_type                status,
   input  logic [sol_pkg::CLIP_W-1:0]         clip_limit,
   input  logic [sol_pkg::OQ_W-1:0]           output_quant,
   input  logic [sol_pkg::ES_W-1:0]           eval_scale,
   input  logic signed [sol_pkg::IN_W-1:0]    req_neuron_value,
   input  logic signed [sol_pkg::IN_W-1:0]    req_weight,
   input  logic signed [sol_pkg::IN_W-1:0]    req_bias_value,
   input  logic                               req_last_item,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic signed [sol_pkg::SUM_W-1:0]   rsp_score
);

   // Multiply-accumulate pipeline: clamp, square, weight product, accumulate.
   logic                               s1_valid_ff, s1_last_ff;
   logic [sol_pkg::CLIP_W-1:0]         s1_clamp_ff, s1_clamp_in;
   logic [sol_pkg::IN_W-1:0]           s1_weight_ff;
   logic                               s2_valid_ff, s2_last_ff;
   logic [sol_pkg::SQ_W-1:0]           s2_sq_ff, s2_sq_in;
   logic [sol_pkg::IN_W-1:0]           s2_weight_ff;
   logic                               s3_valid_ff, s3_last_ff;
   logic [sol_pkg::SUM_W-1:0]          s3_prod_ff, s3_prod_in;
   logic [sol_pkg::SUM_W-1:0]          sum_ff, sum_in;

   // Final scaling.
   logic [sol_pkg::IN_W-1:0]           bias_ff;
   logic                               neg1_ff;
   logic [sol_pkg::DEN_W-1:0]          den_ff;
   logic [sol_pkg::SUM_W-1:0]          t_ff, t_in;
   logic [sol_pkg::DIV_W-1:0]          scaled_ff;
   logic signed [sol_pkg::DIV_W:0]     scaled_in;
   logic [sol_pkg::DIV_W-1:0]          scaled_mag;
   logic [sol_pkg::SUM_W-1:0]          sum_mag;
   logic [sol_pkg::SUM_W-1:0]          q32;
   logic                               rsp_valid_ff;
   logic [sol_pkg::SUM_W-1:0]          rsp_score_ff, rsp_score_in;

   logic                               div_start;
   logic [sol_pkg::DIV_W-1:0]          div_dividend;
   logic [sol_pkg::DEN_W-1:0]          div_divisor;
   logic                               div_busy;
   logic                               div_done;
   logic [sol_pkg::DIV_W-1:0]          div_quotient;

   always_comb begin
      if (req_neuron_value[sol_pkg::IN_W-1]) begin
         s1_clamp_in = '0;
      end else if (req_neuron_value[sol_pkg::CLIP_W-1:0] > clip_limit) begin
         s1_clamp_in = clip_limit;
      end else begin
         s1_clamp_in = req_neuron_value[sol_pkg::CLIP_W-1:0];
      end
      s2_sq_in   = sol_pkg::SQ_W'(s1_clamp_ff) * sol_pkg::SQ_W'(s1_clamp_ff);
      s3_prod_in = sol_pkg::SUM_W'({2'b00, s2_sq_ff} *
                   {{(sol_pkg::SUM_W - sol_pkg::IN_W){s2_weight_ff[sol_pkg::IN_W-1]}},
                    s2_weight_ff});
      if (cmd.div1_start) begin
         sum_in = '0;
      end else if (s3_valid_ff) begin
         sum_in = sum_ff + s3_prod_ff;
      end else begin
         sum_in = sum_ff;
      end
   end

   // Magnitudes feed the unsigned divider; signs are put back afterwards.
   always_comb begin
      sum_mag    = sum_ff[sol_pkg::SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
      scaled_mag = scaled_ff[sol_pkg::DIV_W-1] ? (~scaled_ff + 1'b1) : scaled_ff;
      q32        = div_quotient[sol_pkg::SUM_W-1:0];
      t_in       = (neg1_ff ? (~q32 + 1'b1) : q32) +
                   {{(sol_pkg::SUM_W - sol_pkg::IN_W){bias_ff[sol_pkg::IN_W-1]}}, bias_ff};
      scaled_in  = $signed(t_ff) * $signed({1'b0, eval_scale});
      rsp_score_in = scaled_ff[sol_pkg::DIV_W-1] ? (~q32 + 1'b1) : q32;
      div_start    = cmd.div1_start | cmd.div2_start;
      div_dividend = cmd.div1_start ? sol_pkg::DIV_W'(sum_mag) : scaled_mag;
      div_divisor  = cmd.div1_start ? sol_pkg::DEN_W'(clip_limit) : den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         sum_ff      <= sum_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      s1_clamp_ff  <= s1_clamp_in;
      s1_weight_ff <= req_weight;
      s1_last_ff   <= req_last_item;
      s2_sq_ff     <= s2_sq_in;
      s2_weight_ff <= s1_weight_ff;
      s2_last_ff   <= s1_last_ff;
      s3_prod_ff   <= s3_prod_in;
      s3_last_ff   <= s2_last_ff;
      den_ff       <= sol_pkg::DEN_W'(clip_limit) * sol_pkg::DEN_W'(output_quant);
      if (cmd.accept && req_last_item) begin
         bias_ff <= req_bias_value;
      end
      if (cmd.div1_start) begin
         neg1_ff <= sum_ff[sol_pkg::SUM_W-1];
      end
      if (cmd.load_t) begin
         t_ff <= t_in;
      end
      if (cmd.load_scale) begin
         scaled_ff <= scaled_in[sol_pkg::DIV_W-1:0];
      end
      if (cmd.load_out) begin
         rsp_score_ff <= rsp_score_in;
      end
   end

   sol_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign status.acc_last = s3_valid_ff & s3_last_ff;
   assign status.div_done = div_done;
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_score       = rsp_score_ff;

   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !cmd.accept)
      else $error("new word accepted while the divider is busy");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.div1_start || cmd.div2_start) |-> !div_busy)
      else $error("divider restarted while busy");

   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.div1_start |-> !(s1_valid_ff || s2_valid_ff || s3_valid_ff))
      else $error("sum taken before the MAC pipeline drained");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.div1_start |=> (sum_ff == '0))
      else $error("running sum not cleared after the final neuron");

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while still held");

endmodule

@@ hw/rtl/sol_ctrl.sv @@
module sol_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last_item,
   input  sol_pkg::status_type   status,
   output logic                  req_stall,
   output sol_pkg::cmd_type      cmd
);

   sol_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sol_pkg::ST_IDLE: begin
            if (req_valid && req_last_item) begin
               state_in = sol_pkg::ST_DRAIN;
            end
         end
         sol_pkg::ST_DRAIN: begin
            if (status.acc_last) begin
               state_in = sol_pkg::ST_DIV1_START;
            end
         end
         sol_pkg::ST_DIV1_START: state_in = sol_pkg::ST_DIV1_WAIT;
         sol_pkg::ST_DIV1_WAIT: begin
            if (status.div_done) begin
               state_in = sol_pkg::ST_BIAS;
            end
         end
         sol_pkg::ST_BIAS:       state_in = sol_pkg::ST_SCALE;
         sol_pkg::ST_SCALE:      state_in = sol_pkg::ST_DIV2_START;
         sol_pkg::ST_DIV2_START: state_in = sol_pkg::ST_DIV2_WAIT;
         sol_pkg::ST_DIV2_WAIT: begin
            if (status.div_done) begin
               state_in = sol_pkg::ST_OUT;
            end
         end
         sol_pkg::ST_OUT: begin
            if (status.out_free) begin
               state_in = sol_pkg::ST_IDLE;
            end
         end
         default: state_in = sol_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sol_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         sol_pkg::ST_DIV1_START: cmd.div1_start = 1'b1;
         sol_pkg::ST_BIAS:       cmd.load_t     = 1'b1;
         sol_pkg::ST_SCALE:      cmd.load_scale = 1'b1;
         sol_pkg::ST_DIV2_START: cmd.div2_start = 1'b1;
         sol_pkg::ST_OUT:        cmd.load_out   = status.out_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sol_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ verif/screlu_output_layer_core_tb.sv @@
`timescale 1ns / 1ps

module screlu_output_layer_core_tb;

   // Index three lies past the last register, so a write there must change nothing.
   localparam logic [sol_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // A closing word keeps the block busy until its score is loaded. Add the
   // longest sender gap and the longest receiver stall, and the slowest correct
   // run still has far fewer idle cycles in a row than this limit.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles allowed after the last score before the registers are touched.
   localparam int SETTLE_CYCLES  = 10;
   // Cycles watched after the last score at the end of the run.
   localparam int TAIL_CYCLES    = 150;
   localparam int MAX_REPORTS    = 10;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   csr_valid = 1'b0;
   logic                                   csr_ready;
   logic [sol_pkg::CSR_IDX_W-1:0]          csr_index = '0;
   logic [sol_pkg::CSR_DATA_W-1:0]         csr_wdata = '0;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic signed [sol_pkg::IN_W-1:0]        req_neuron_value = '0;
   logic signed [sol_pkg::IN_W-1:0]        req_weight = '0;
   logic signed [sol_pkg::IN_W-1:0]        req_bias_value = '0;
   logic                                   req_last_item = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic signed [sol_pkg::SUM_W-1:0]       rsp_score;

   // Local copy of the configuration registers and of the running sum.
   logic [sol_pkg::CLIP_W-1:0]             clip_reg = sol_pkg::CLIP_LIMIT_RST;
   logic [sol_pkg::OQ_W-1:0]               oq_reg = sol_pkg::OUTPUT_QUANT_RST;
   logic [sol_pkg::ES_W-1:0]               es_reg = sol_pkg::EVAL_SCALE_RST;
   logic [sol_pkg::SUM_W-1:0]              running_total = '0;

   // Scores predicted for closed evaluations, oldest first.
   logic [sol_pkg::SUM_W-1:0]              score_q[$];

   int                                     mismatch_count = 0;
   int                                     idle_cycles = 0;
   int                                     stall_left = 5;
   logic [sol_pkg::SUM_W-1:0]              want_score;
   // When set, the sender or the receiver runs without gaps for a stretch.
   bit                                     send_quiet = 1'b0;
   bit                                     recv_quiet = 1'b0;

   screlu_output_layer_core u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_neuron_value (req_neuron_value),
      .req_weight       (req_weight),
      .req_bias_value   (req_bias_value),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_score        (rsp_score)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Folds one accepted neuron word into the local running sum. On a closing
   // word the sum is quantized, biased, scaled and pushed as the next score.
   // Everything before the division wraps at 32 bits, the scaling runs in 64.
   function automatic void absorb_word(input logic signed [sol_pkg::IN_W-1:0] nv,
                                       input logic signed [sol_pkg::IN_W-1:0] wt,
                                       input logic signed [sol_pkg::IN_W-1:0] bias,
                                       input logic last);
      longint                    lim;
      longint                    oq;
      longint                    clamped;
      longint                    quot;
      logic [sol_pkg::SUM_W-1:0] sq;
      logic [sol_pkg::SUM_W-1:0] wt_ext;
      logic [sol_pkg::SUM_W-1:0] biased;
      // A zero clamp ceiling or quantizer behaves as one.
      lim = (clip_reg == '0) ? 64'd1 : 64'(clip_reg);
      oq  = (oq_reg == '0) ? 64'd1 : 64'(oq_reg);
      if (nv < 0) clamped = 0;
      else if (longint'(nv) > lim) clamped = lim;
      else clamped = longint'(nv);
      sq = sol_pkg::SUM_W'(clamped * clamped);
      wt_ext = {{(sol_pkg::SUM_W-sol_pkg::IN_W){wt[sol_pkg::IN_W-1]}}, wt};
      running_total = running_total + sq * wt_ext;
      // The bias only matters on the word that closes an evaluation.
      if (!last) return;
      quot = longint'($signed(running_total)) / lim;
      biased = quot[sol_pkg::SUM_W-1:0] +
               {{(sol_pkg::SUM_W-sol_pkg::IN_W){bias[sol_pkg::IN_W-1]}}, bias};
      quot = (longint'($signed(biased)) * longint'(es_reg)) / (lim * oq);
      // Only the low 32 bits of a wide quotient reach the score port.
      score_q.push_back(quot[sol_pkg::SUM_W-1:0]);
      running_total = '0;
   endfunction

   function automatic void log_mismatch(input string what,
                                        input logic [sol_pkg::SUM_W-1:0] want,
                                        input logic [sol_pkg::SUM_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, $signed(want),
                  $signed(got));
   endfunction

   // Neuron values mostly fall inside the clamp window, with a share of
   // window edges, negatives and arbitrary 16-bit values.
   function automatic logic signed [sol_pkg::IN_W-1:0] pick_neuron();
      int unsigned lim;
      lim = (clip_reg == '0) ? 1 : clip_reg;
      case ($urandom_range(0, 9))
         0, 1: return sol_pkg::IN_W'($urandom);
         2: begin
            case ($urandom_range(0, 5))
               0: return '0;
               1: return -16'sd1;
               2: return sol_pkg::IN_W'(lim);
               3: return sol_pkg::IN_W'(lim + 1);
               4: return 16'sh8000;
               default: return 16'sh7fff;
            endcase
         end
         default: return sol_pkg::IN_W'($urandom_range(0, lim));
      endcase
   endfunction

   function automatic logic signed [sol_pkg::IN_W-1:0] pick_weight();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return sol_pkg::IN_W'($urandom);
      endcase
   endfunction

   // Checks each score word as it is taken, then draws how long the receiver
   // holds off the next one. The hold only counts down while a score is
   // offered, so stalls land on every stage of the hand-off.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (score_q.size() == 0) begin
               log_mismatch("score with no evaluation pending", 'x, rsp_score);
            end else begin
               want_score = score_q.pop_front();
               if (rsp_score !== want_score) log_mismatch("score", want_score, rsp_score);
            end
            stall_left = recv_quiet ? 0 : $urandom_range(0, 17);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // Ends the run when no channel has moved a word for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Offers one neuron word after a random gap and waits until it is taken.
   // Valid stays high into the next call when that call draws no gap.
   task automatic send_neuron(input logic signed [sol_pkg::IN_W-1:0] nv,
                              input logic signed [sol_pkg::IN_W-1:0] wt,
                              input logic signed [sol_pkg::IN_W-1:0] bias,
                              input logic last);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_neuron_value <= nv;
      req_weight       <= wt;
      req_bias_value   <= bias;
      req_last_item    <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      absorb_word(nv, wt, bias, last);
   endtask

   // Holds the sender until every predicted score has come back, then lets
   // the divider and the pipeline settle.
   task automatic drain_scores();
      req_valid <= 1'b0;
      while (score_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [sol_pkg::CSR_IDX_W-1:0] idx,
                          input logic [sol_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         sol_pkg::CSR_CLIP_LIMIT:   clip_reg = data;
         sol_pkg::CSR_OUTPUT_QUANT: oq_reg = data[sol_pkg::OQ_W-1:0];
         sol_pkg::CSR_EVAL_SCALE:   es_reg = data[sol_pkg::ES_W-1:0];
         default: ;
      endcase
   endtask

   // Rewrites all three registers once the block is idle. The spare index
   // gets a random value that must leave the settings alone.
   task automatic program_regs(input logic [sol_pkg::CSR_DATA_W-1:0] clip_w,
                               input logic [sol_pkg::CSR_DATA_W-1:0] oq_w,
                               input logic [sol_pkg::CSR_DATA_W-1:0] es_w);
      drain_scores();
      put_reg(sol_pkg::CSR_CLIP_LIMIT, clip_w);
      put_reg(CSR_SPARE, sol_pkg::CSR_DATA_W'($urandom));
      put_reg(sol_pkg::CSR_OUTPUT_QUANT, oq_w);
      put_reg(sol_pkg::CSR_EVAL_SCALE, es_w);
      csr_valid <= 1'b0;
   endtask

   // Settings from reset: clamping at both ends, extreme weights and biases,
   // and a bias on an inner word that must be ignored.
   task automatic test_reset_defaults();
      send_neuron(16'sd255, 16'sh7fff, 16'sh1234, 1'b0);
      send_neuron(16'sh8000, 16'sh8000, -16'sd1, 1'b0);
      send_neuron(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1);
      send_neuron(16'sd256, 16'sd1, 16'sh8000, 1'b1);
      send_neuron(16'sd0, 16'sd0, 16'sd0, 1'b1);
   endtask

   // Largest squares times the largest weights overflow both the product and
   // the running sum.
   task automatic test_product_wrap();
      program_regs(15'd32767, 15'd1, 15'd1);
      send_neuron(16'sh7fff, 16'sh8000, 16'sd0, 1'b0);
      send_neuron(16'sh7fff, 16'sh7fff, 16'sd0, 1'b0);
      send_neuron(16'sh7fff, 16'sh8000, 16'sh8000, 1'b1);
   endtask

   // A zero clamp ceiling and quantizer behave as one, a zero scale gives zero.
   task automatic test_zero_registers();
      program_regs(15'd0, 15'd0, 15'd4096);
      send_neuron(16'sh7fff, 16'sh7fff, 16'sd100, 1'b1);
      send_neuron(-16'sd5, 16'sd7, -16'sd1, 1'b1);
      program_regs(15'd300, 15'd0, 15'd0);
      send_neuron(16'sd200, -16'sd1000, 16'sd5, 1'b1);
   endtask

   // With unit divisors and the widest scale the final quotient no longer
   // fits in a signed 32-bit score and only its low 32 bits come out.
   task automatic test_wide_score();
      program_regs(15'd1, 15'd1, 15'h1fff);
      repeat (8) send_neuron(16'sd1, 16'sh7fff, 16'sd0, 1'b0);
      send_neuron(16'sd1, 16'sh7fff, 16'sh7fff, 1'b1);
   endtask

   // Random evaluations over a series of settings, the corners first. Most
   // evaluations are short, a few run long, and the sender sometimes waits
   // for every score before it goes on.
   task automatic test_random_evaluations(input int total_words);
      int budget;
      int sent;
      int len;
      logic [sol_pkg::CSR_DATA_W-1:0] clip_w;
      logic [sol_pkg::CSR_DATA_W-1:0] oq_w;
      logic [sol_pkg::CSR_DATA_W-1:0] es_w;
      budget = total_words / 8;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin clip_w = 15'd1;     oq_w = 15'd1;    es_w = 15'd4096; end
            1: begin clip_w = 15'd32767; oq_w = 15'd1024; es_w = 15'd1;    end
            2: begin clip_w = 15'd32767; oq_w = 15'd1;    es_w = 15'd4096; end
            3: begin
               clip_w = sol_pkg::CLIP_LIMIT_RST;
               oq_w = sol_pkg::CSR_DATA_W'(sol_pkg::OUTPUT_QUANT_RST);
               es_w = sol_pkg::CSR_DATA_W'(sol_pkg::EVAL_SCALE_RST);
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: clip_w = sol_pkg::CSR_DATA_W'($urandom_range(1, 16));
                  1: clip_w = sol_pkg::CSR_DATA_W'($urandom_range(100, 1000));
                  default: clip_w = sol_pkg::CSR_DATA_W'($urandom_range(0, 32767));
               endcase
               // Now and then the upper data bits are set beyond the register.
               oq_w = ($urandom_range(0, 3) == 0)
                      ? sol_pkg::CSR_DATA_W'($urandom)
                      : sol_pkg::CSR_DATA_W'($urandom_range(1, 1024));
               es_w = ($urandom_range(0, 3) == 0)
                      ? sol_pkg::CSR_DATA_W'($urandom)
                      : sol_pkg::CSR_DATA_W'($urandom_range(1, 4096));
            end
         endcase
         program_regs(clip_w, oq_w, es_w);
         sent = 0;
         while (sent < budget) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 24) == 0) drain_scores();
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
               send_neuron(pick_neuron(), pick_weight(), sol_pkg::IN_W'($urandom),
                           i == len - 1);
            sent += len;
         end
      end
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_product_wrap();
      test_zero_registers();
      test_wide_score();
      test_random_evaluations(1260);
      drain_scores();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && score_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/sol_pkg.sv
hw/rtl/sol_div.sv
hw/rtl/sol_datapath.sv
hw/rtl/sol_ctrl.sv
hw/rtl/screlu_output_layer_core.sv
verif/screlu_output_layer_core_tb.sv
